// ----- rtl/core/kpu_pkg.sv -----
package kpu_pkg;

  // fixed data format, signed q16.16
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int FRAC_BITS = 16;
  localparam int DIM_W     = 5;
  localparam int POS_W     = 4;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 4;

  // request codes, also used as queue operation codes
  localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_A = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_B = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 4'd7;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [PROD_W-1:0] SAT_MAX_P  = (PROD_W'(64'sd1) <<< (DATA_W - 1)) - 1;
  localparam logic signed [PROD_W-1:0] SAT_MIN_P  = -SAT_MAX_P - 1;
  localparam logic signed [DATA_W-1:0] SAT_MAX    = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN    = {1'b1, {(DATA_W - 1){1'b0}}};

  typedef struct packed {
    logic                     trans_a;
    logic                     trans_b;
    logic [DIM_W-1:0]         rows_a;
    logic [DIM_W-1:0]         cols_a;
    logic [DIM_W-1:0]         rows_b;
    logic [DIM_W-1:0]         cols_b;
    logic signed [DATA_W-1:0] alpha_gain;
    logic signed [DATA_W-1:0] beta_gain;
  } cfg_t;

  // round half up, drop fraction bits, saturate to data width
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    logic signed [PROD_W-1:0] q;
    r = p + ROUND_HALF;
    q = r >>> FRAC_BITS;
    if (q > SAT_MAX_P) begin
      return SAT_MAX;
    end else if (q < SAT_MIN_P) begin
      return SAT_MIN;
    end
    return q[DATA_W-1:0];
  endfunction

  // saturating add of two data words
  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] x,
                                                       input logic signed [DATA_W-1:0] y);
    logic signed [DATA_W:0] s;
    s = {x[DATA_W-1], x} + {y[DATA_W-1], y};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? SAT_MIN : SAT_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

// ----- rtl/core/kpu_front.sv -----
module kpu_front #(
  parameter int MAX_DIM = 16,
  parameter int AW      = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kpu_pkg::cfg_t                       cfg_i,
  input  logic                                accept_i,
  input  logic [kpu_pkg::REQ_W-1:0]           req_type_i,
  input  logic [kpu_pkg::POS_W-1:0]           elem_row_i,
  input  logic [kpu_pkg::POS_W-1:0]           elem_col_i,
  input  logic signed [kpu_pkg::DATA_W-1:0]   elem_value_i,
  output logic                                push_o,
  output logic [kpu_pkg::REQ_W-1:0]           op_o,
  output logic [AW-1:0]                       addr_a_o,
  output logic [AW-1:0]                       addr_b_o,
  output logic signed [kpu_pkg::DATA_W-1:0]   value_o,
  output logic                                last_o
);

  localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CMP_W = ((CW > kpu_pkg::DIM_W) ? CW : kpu_pkg::DIM_W) + 1;

  // position counters: l fastest, then i, then k, then j
  logic [CW-1:0] l_q, l_d, i_q, i_d, k_q, k_d, j_q, j_d;
  logic          wrap_l, wrap_i, wrap_k, wrap_j;
  logic          in_range;
  logic          is_load, is_update;

  assign wrap_l = (CMP_W'(l_q) + CMP_W'(1)) >= CMP_W'(cfg_i.rows_b);
  assign wrap_i = (CMP_W'(i_q) + CMP_W'(1)) >= CMP_W'(cfg_i.rows_a);
  assign wrap_k = (CMP_W'(k_q) + CMP_W'(1)) >= CMP_W'(cfg_i.cols_b);
  assign wrap_j = (CMP_W'(j_q) + CMP_W'(1)) >= CMP_W'(cfg_i.cols_a);

  assign in_range  = (int'(elem_row_i) < MAX_DIM) && (int'(elem_col_i) < MAX_DIM);
  assign is_load   = (req_type_i == kpu_pkg::REQ_LOAD_A) || (req_type_i == kpu_pkg::REQ_LOAD_B);
  assign is_update = (req_type_i == kpu_pkg::REQ_UPDATE);

  // classify transaction and build queue entry
  always_comb begin
    push_o   = accept_i && ((is_load && in_range) || is_update);
    op_o     = req_type_i;
    value_o  = elem_value_i;
    last_o   = wrap_l && wrap_i && wrap_k && wrap_j;
    addr_b_o = cfg_i.trans_b ? AW'(int'(k_q) * MAX_DIM + int'(l_q))
                             : AW'(int'(l_q) * MAX_DIM + int'(k_q));
    if (is_load) begin
      addr_a_o = AW'(int'(elem_row_i) * MAX_DIM + int'(elem_col_i));
    end else begin
      addr_a_o = cfg_i.trans_a ? AW'(int'(j_q) * MAX_DIM + int'(i_q))
                               : AW'(int'(i_q) * MAX_DIM + int'(j_q));
    end
  end

  // nested counter advance on each update
  always_comb begin
    l_d = l_q;
    i_d = i_q;
    k_d = k_q;
    j_d = j_q;
    if (accept_i && is_update) begin
      l_d = wrap_l ? '0 : l_q + CW'(1);
      if (wrap_l) begin
        i_d = wrap_i ? '0 : i_q + CW'(1);
        if (wrap_i) begin
          k_d = wrap_k ? '0 : k_q + CW'(1);
          if (wrap_k) begin
            j_d = wrap_j ? '0 : j_q + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q <= '0;
      i_q <= '0;
      k_q <= '0;
      j_q <= '0;
    end else begin
      l_q <= l_d;
      i_q <= i_d;
      k_q <= k_d;
      j_q <= j_d;
    end
  end

endmodule

// ----- rtl/core/kpu_queue.sv -----
module kpu_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             pop_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = $clog2(kpu_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(kpu_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [kpu_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             empty;

  assign empty  = (cnt_q == '0);
  assign full_o = (cnt_q == NW'(kpu_pkg::QUEUE_DEPTH));
  // back side never stalls, so an entry leaves as soon as it is there
  assign pop_o  = !empty;
  assign data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PW'(1) : wr_q;
    rd_d  = pop_o ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + NW'(push_i) - NW'(pop_o);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/kpu_back.sv -----
module kpu_back #(
  parameter int MAX_DIM = 16,
  parameter int AW      = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  kpu_pkg::cfg_t                     cfg_i,
  input  logic                              pop_i,
  input  logic [kpu_pkg::REQ_W-1:0]         op_i,
  input  logic [AW-1:0]                     addr_a_i,
  input  logic [AW-1:0]                     addr_b_i,
  input  logic signed [kpu_pkg::DATA_W-1:0] value_i,
  input  logic                              last_i,
  output logic                              c_valid_o,
  output logic signed [kpu_pkg::DATA_W-1:0] c_value_o,
  output logic                              c_last_o
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int DW    = kpu_pkg::DATA_W;
  localparam int PW    = kpu_pkg::PROD_W;

  logic signed [DW-1:0] a_mem [DEPTH];
  logic signed [DW-1:0] b_mem [DEPTH];

  logic                 v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic                 upd;
  logic signed [DW-1:0] a1_q, b1_q, c1_q, b2_q, b3_q;
  logic signed [PW-1:0] pa2_q, pc2_q, pb4_q;
  logic signed [DW-1:0] ab3_q, bc3_q, bc4_q, bc5_q, t5_q, sum6_q;
  logic                 last1_q, last2_q, last3_q, last4_q, last5_q, last6_q;

  assign upd = pop_i && (op_i == kpu_pkg::REQ_UPDATE);

  // stores: loads write, updates read with registered data
  always_ff @(posedge clk_i) begin
    if (pop_i && (op_i == kpu_pkg::REQ_LOAD_A)) begin
      a_mem[addr_a_i] <= value_i;
    end
    a1_q <= a_mem[addr_a_i];
  end

  always_ff @(posedge clk_i) begin
    if (pop_i && (op_i == kpu_pkg::REQ_LOAD_B)) begin
      b_mem[addr_a_i] <= value_i;
    end
    b1_q <= b_mem[addr_b_i];
  end

  // arithmetic pipeline payload
  always_ff @(posedge clk_i) begin
    c1_q    <= value_i;
    last1_q <= last_i;
    // raw products alpha*a and beta*c
    pa2_q   <= cfg_i.alpha_gain * a1_q;
    pc2_q   <= cfg_i.beta_gain * c1_q;
    b2_q    <= b1_q;
    last2_q <= last1_q;
    // round and saturate
    ab3_q   <= kpu_pkg::round_sat(pa2_q);
    bc3_q   <= kpu_pkg::round_sat(pc2_q);
    b3_q    <= b2_q;
    last3_q <= last2_q;
    // second product
    pb4_q   <= ab3_q * b3_q;
    bc4_q   <= bc3_q;
    last4_q <= last3_q;
    t5_q    <= kpu_pkg::round_sat(pb4_q);
    bc5_q   <= bc4_q;
    last5_q <= last4_q;
    // beta*c is exactly zero when beta is zero, so it can always be added
    sum6_q  <= kpu_pkg::sat_add(t5_q, bc5_q);
    last6_q <= last5_q;
  end

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= upd;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  assign c_valid_o = v6_q;
  assign c_value_o = sum6_q;
  assign c_last_o  = v6_q && last6_q;

endmodule

// ----- rtl/core/kronecker_product_update_core.sv -----
// channel   direction  handshake                     payload
// request   in         start & !busy                 req_type_i, elem_row_i, elem_col_i,
//                                                    elem_value_i
// config    in         cfg_valid_i & cfg_ready_o     cfg_index_i, cfg_data_i
// result    out        c_valid_o, one cycle strobe   c_value_o, c_last_o
//
// one transaction is taken per cycle while busy is low; an update passes through
// the queue, then the store read, two multiply and two round/saturate stages and
// the final saturating add.
// busy rises only when the four-entry queue is full; the back end drains one
// entry each cycle and the result side cannot stall, so busy stays low.
// reset clears counters, queue and valid bits; stores are undefined until loaded.
module kronecker_product_update_core #(
  parameter int MAX_DIM = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [kpu_pkg::REQ_W-1:0]             req_type_i,
  input  logic [kpu_pkg::POS_W-1:0]             elem_row_i,
  input  logic [kpu_pkg::POS_W-1:0]             elem_col_i,
  input  logic signed [kpu_pkg::DATA_W-1:0]     elem_value_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [kpu_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [kpu_pkg::DATA_W-1:0]            cfg_data_i,
  output logic                                  c_valid_o,
  output logic signed [kpu_pkg::DATA_W-1:0]     c_value_o,
  output logic                                  c_last_o
);

  localparam int AW   = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int DW   = kpu_pkg::DATA_W;
  localparam int RW   = kpu_pkg::REQ_W;
  localparam int QW   = RW + 2 * AW + DW + 1;

  kpu_pkg::cfg_t cfg_q, cfg_d;

  logic              accept;
  logic              full;
  logic              push, pop;
  logic [RW-1:0]     f_op, b_op;
  logic [AW-1:0]     f_addr_a, f_addr_b, b_addr_a, b_addr_b;
  logic signed [DW-1:0] f_value, b_value;
  logic              f_last, b_last;
  logic [QW-1:0]     q_in, q_out;

  // clamp a dimension to 1..MAX_DIM
  function automatic logic [kpu_pkg::DIM_W-1:0] clamp_dim(input logic [kpu_pkg::DIM_W-1:0] v);
    if (v == '0) begin
      return kpu_pkg::DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      return kpu_pkg::DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  assign accept      = start && !busy;
  assign busy        = full;
  assign cfg_ready_o = 1'b1;

  // configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        kpu_pkg::CFG_TRANS_A: cfg_d.trans_a    = cfg_data_i[0];
        kpu_pkg::CFG_TRANS_B: cfg_d.trans_b    = cfg_data_i[0];
        kpu_pkg::CFG_ROWS_A:  cfg_d.rows_a     = clamp_dim(cfg_data_i[kpu_pkg::DIM_W-1:0]);
        kpu_pkg::CFG_COLS_A:  cfg_d.cols_a     = clamp_dim(cfg_data_i[kpu_pkg::DIM_W-1:0]);
        kpu_pkg::CFG_ROWS_B:  cfg_d.rows_b     = clamp_dim(cfg_data_i[kpu_pkg::DIM_W-1:0]);
        kpu_pkg::CFG_COLS_B:  cfg_d.cols_b     = clamp_dim(cfg_data_i[kpu_pkg::DIM_W-1:0]);
        kpu_pkg::CFG_ALPHA:   cfg_d.alpha_gain = cfg_data_i;
        kpu_pkg::CFG_BETA:    cfg_d.beta_gain  = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trans_a    <= 1'b0;
      cfg_q.trans_b    <= 1'b0;
      cfg_q.rows_a     <= kpu_pkg::DIM_W'(1);
      cfg_q.cols_a     <= kpu_pkg::DIM_W'(1);
      cfg_q.rows_b     <= kpu_pkg::DIM_W'(1);
      cfg_q.cols_b     <= kpu_pkg::DIM_W'(1);
      cfg_q.alpha_gain <= DW'(1) <<< kpu_pkg::FRAC_BITS;
      cfg_q.beta_gain  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end: classify and index
  kpu_front #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .req_type_i   (req_type_i),
    .elem_row_i   (elem_row_i),
    .elem_col_i   (elem_col_i),
    .elem_value_i (elem_value_i),
    .push_o       (push),
    .op_o         (f_op),
    .addr_a_o     (f_addr_a),
    .addr_b_o     (f_addr_b),
    .value_o      (f_value),
    .last_o       (f_last)
  );

  assign q_in = {f_op, f_addr_a, f_addr_b, f_value, f_last};

  // queue between front and back
  kpu_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .full_o (full),
    .pop_o  (pop),
    .data_o (q_out)
  );

  assign {b_op, b_addr_a, b_addr_b, b_value, b_last} = q_out;

  // back end: stores and arithmetic
  kpu_back #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .pop_i     (pop),
    .op_i      (b_op),
    .addr_a_i  (b_addr_a),
    .addr_b_i  (b_addr_b),
    .value_i   (b_value),
    .last_i    (b_last),
    .c_valid_o (c_valid_o),
    .c_value_o (c_value_o),
    .c_last_o  (c_last_o)
  );

endmodule

// ----- rtl/core/kpu_checker.sv -----
module kpu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic cfg_ready_o,
  input logic c_valid_o,
  input logic c_last_o
);

  // last flag only rides on a result
  assert property (@(posedge clk_i) disable iff (!rst_ni) c_last_o |-> c_valid_o)
    else $error("last flag without result");

  // queue drains every cycle, so the request side never sees busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) start |-> !busy)
    else $error("busy raised while queue drains each cycle");

  // config channel always ready
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config channel not ready");

  // no result directly out of reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !c_valid_o)
    else $error("result strobe right after reset");

endmodule

bind kronecker_product_update_core kpu_checker u_kpu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .cfg_ready_o (cfg_ready_o),
  .c_valid_o   (c_valid_o),
  .c_last_o    (c_last_o)
);

// ----- sim/tb_kronecker_product_update_core.sv -----
`timescale 1ns / 100ps

module tb_kronecker_product_update_core;

  localparam int STORE_DIM    = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;

  // request code the block must ignore
  localparam logic [kpu_pkg::REQ_W-1:0] REQ_NONE = 2'd3;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic signed [kpu_pkg::DATA_W-1:0] ONE_Q = 32'sh0001_0000;
  localparam logic signed [kpu_pkg::DATA_W-1:0] MAX_Q = 32'sh7fff_ffff;
  localparam logic signed [kpu_pkg::DATA_W-1:0] MIN_Q = 32'sh8000_0000;

  typedef struct packed {
    logic signed [kpu_pkg::DATA_W-1:0] value;
    logic                              last;
  } c_elem_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic [kpu_pkg::REQ_W-1:0]         req_type_i;
  logic [kpu_pkg::POS_W-1:0]         elem_row_i;
  logic [kpu_pkg::POS_W-1:0]         elem_col_i;
  logic signed [kpu_pkg::DATA_W-1:0] elem_value_i;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [kpu_pkg::CFG_IDX_W-1:0]     cfg_index_i;
  logic [kpu_pkg::DATA_W-1:0]        cfg_data_i;
  logic                              c_valid_o;
  logic signed [kpu_pkg::DATA_W-1:0] c_value_o;
  logic                              c_last_o;

  // local copy of the block's configuration
  bit                                cur_trans_a = 1'b0;
  bit                                cur_trans_b = 1'b0;
  int                                cur_rows_a  = 1;
  int                                cur_cols_a  = 1;
  int                                cur_rows_b  = 1;
  int                                cur_cols_b  = 1;
  logic signed [kpu_pkg::DATA_W-1:0] cur_alpha   = ONE_Q;
  logic signed [kpu_pkg::DATA_W-1:0] cur_beta    = '0;

  // local copy of the stores and the element counters
  logic signed [kpu_pkg::DATA_W-1:0] a_mem [STORE_DIM*STORE_DIM];
  logic signed [kpu_pkg::DATA_W-1:0] b_mem [STORE_DIM*STORE_DIM];
  bit                                a_loaded [STORE_DIM*STORE_DIM];
  bit                                b_loaded [STORE_DIM*STORE_DIM];
  int                                cnt_b_row = 0;
  int                                cnt_a_row = 0;
  int                                cnt_b_col = 0;
  int                                cnt_a_col = 0;

  c_elem_t                           expected_c [$];
  int                                err_count   = 0;
  int                                cycle_count = 0;
  bit                                idle_on     = 1'b1;

  kronecker_product_update_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .elem_row_i   (elem_row_i),
    .elem_col_i   (elem_col_i),
    .elem_value_i (elem_value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .c_valid_o    (c_valid_o),
    .c_value_o    (c_value_o),
    .c_last_o     (c_last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** kronecker_product_update_core: FAILED **");
      $finish;
    end
  end

  // compare each result with the oldest expected element
  always @(posedge clk_i) begin : check_results
    c_elem_t e;
    if (rst_ni && c_valid_o === 1'b1) begin
      if (expected_c.size() == 0) begin
        $error("c_value: expected nothing, got %0d", c_value_o);
        err_count++;
      end else begin
        e = expected_c.pop_front();
        if (c_value_o !== e.value) begin
          $error("c_value: expected %0d, got %0d", e.value, c_value_o);
          err_count++;
        end
        if (c_last_o !== e.last) begin
          $error("c_last: expected %0b, got %0b", e.last, c_last_o);
          err_count++;
        end
      end
    end
  end

  // saturate to the signed data range
  function automatic logic signed [kpu_pkg::DATA_W-1:0] clip_q(input longint v);
    if (v > Q_MAX) return MAX_Q;
    if (v < Q_MIN) return MIN_Q;
    return v[kpu_pkg::DATA_W-1:0];
  endfunction

  // q16.16 product, half rounds towards plus infinity
  function automatic logic signed [kpu_pkg::DATA_W-1:0] fixed_mul(
      input logic signed [kpu_pkg::DATA_W-1:0] x,
      input logic signed [kpu_pkg::DATA_W-1:0] y);
    longint p;
    p = longint'(x) * longint'(y) + 64'sd32768;
    return clip_q(p >>> 16);
  endfunction

  function automatic int clamp_dim(input logic [kpu_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > STORE_DIM) return STORE_DIM;
    return int'(v);
  endfunction

  // store positions read by the next update
  function automatic int a_index();
    if (cur_trans_a) return cnt_a_col * STORE_DIM + cnt_a_row;
    return cnt_a_row * STORE_DIM + cnt_a_col;
  endfunction

  function automatic int b_index();
    if (cur_trans_b) return cnt_b_col * STORE_DIM + cnt_b_row;
    return cnt_b_row * STORE_DIM + cnt_b_col;
  endfunction

  task automatic wrap_count(inout int cnt, input int dim, output bit wrapped);
    wrapped = (cnt + 1 >= dim);
    cnt     = wrapped ? 0 : cnt + 1;
  endtask

  // expected updated element, then step the column-major walk
  task automatic compute_c_element(input logic signed [kpu_pkg::DATA_W-1:0] old_c);
    logic signed [kpu_pkg::DATA_W-1:0] kron;
    c_elem_t                           e;
    bit                                wrapped;
    kron = fixed_mul(fixed_mul(cur_alpha, a_mem[a_index()]), b_mem[b_index()]);
    if (cur_beta != 0) begin
      e.value = clip_q(longint'(kron) + longint'(fixed_mul(cur_beta, old_c)));
    end else begin
      e.value = kron;
    end
    e.last = 1'b0;
    wrap_count(cnt_b_row, cur_rows_b, wrapped);
    if (wrapped) begin
      wrap_count(cnt_a_row, cur_rows_a, wrapped);
      if (wrapped) begin
        wrap_count(cnt_b_col, cur_cols_b, wrapped);
        if (wrapped) begin
          wrap_count(cnt_a_col, cur_cols_a, wrapped);
          e.last = wrapped;
        end
      end
    end
    expected_c.push_back(e);
  endtask

  function automatic logic signed [kpu_pkg::DATA_W-1:0] rand_q();
    case ($urandom_range(0, 9))
      0:       return MAX_Q;
      1:       return MIN_Q;
      2:       return '0;
      3, 4:    return $urandom();
      5, 6:    return 32'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return 32'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic logic signed [kpu_pkg::DATA_W-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ONE_Q;
      2:       return MAX_Q;
      3:       return MIN_Q;
      4:       return $urandom();
      default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic [kpu_pkg::DIM_W-1:0] pick_dim();
    return kpu_pkg::DIM_W'($urandom_range(1, 4));
  endfunction

  // one request transaction; the local copy follows on acceptance
  task automatic send_item(input logic [kpu_pkg::REQ_W-1:0] req,
                           input logic [kpu_pkg::POS_W-1:0] row,
                           input logic [kpu_pkg::POS_W-1:0] col,
                           input logic signed [kpu_pkg::DATA_W-1:0] val);
    start        <= 1'b1;
    req_type_i   <= req;
    elem_row_i   <= row;
    elem_col_i   <= col;
    elem_value_i <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
    case (req)
      kpu_pkg::REQ_LOAD_A: begin
        a_mem[row * STORE_DIM + col]    = val;
        a_loaded[row * STORE_DIM + col] = 1'b1;
      end
      kpu_pkg::REQ_LOAD_B: begin
        b_mem[row * STORE_DIM + col]    = val;
        b_loaded[row * STORE_DIM + col] = 1'b1;
      end
      kpu_pkg::REQ_UPDATE: compute_c_element(val);
      default: ;
    endcase
  endtask

  // update request, loading first any store entry it would read unwritten
  task automatic send_update(input logic signed [kpu_pkg::DATA_W-1:0] old_c);
    int ai;
    int bi;
    ai = a_index();
    bi = b_index();
    if (!a_loaded[ai]) send_item(kpu_pkg::REQ_LOAD_A, kpu_pkg::POS_W'(ai / STORE_DIM),
                                 kpu_pkg::POS_W'(ai % STORE_DIM), rand_q());
    if (!b_loaded[bi]) send_item(kpu_pkg::REQ_LOAD_B, kpu_pkg::POS_W'(bi / STORE_DIM),
                                 kpu_pkg::POS_W'(bi % STORE_DIM), rand_q());
    send_item(kpu_pkg::REQ_UPDATE, kpu_pkg::POS_W'($urandom_range(0, 15)),
              kpu_pkg::POS_W'($urandom_range(0, 15)), old_c);
  endtask

  task automatic send_load(input logic [kpu_pkg::REQ_W-1:0] req);
    send_item(req, kpu_pkg::POS_W'($urandom_range(0, 15)),
              kpu_pkg::POS_W'($urandom_range(0, 15)), rand_q());
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // hold requests until every expected element is back and the pipe is empty
  task automatic drain_results();
    start <= 1'b0;
    while (expected_c.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [kpu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kpu_pkg::DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      kpu_pkg::CFG_TRANS_A: cur_trans_a = data[0];
      kpu_pkg::CFG_TRANS_B: cur_trans_b = data[0];
      kpu_pkg::CFG_ROWS_A:  cur_rows_a  = clamp_dim(data[kpu_pkg::DIM_W-1:0]);
      kpu_pkg::CFG_COLS_A:  cur_cols_a  = clamp_dim(data[kpu_pkg::DIM_W-1:0]);
      kpu_pkg::CFG_ROWS_B:  cur_rows_b  = clamp_dim(data[kpu_pkg::DIM_W-1:0]);
      kpu_pkg::CFG_COLS_B:  cur_cols_b  = clamp_dim(data[kpu_pkg::DIM_W-1:0]);
      kpu_pkg::CFG_ALPHA:   cur_alpha   = data;
      kpu_pkg::CFG_BETA:    cur_beta    = data;
      default: ;
    endcase
  endtask

  // full register set while idle; unused upper bits carry noise
  task automatic apply_setting(input bit ta, input bit tb,
                               input logic [kpu_pkg::DIM_W-1:0] ra,
                               input logic [kpu_pkg::DIM_W-1:0] ca,
                               input logic [kpu_pkg::DIM_W-1:0] rb,
                               input logic [kpu_pkg::DIM_W-1:0] cb,
                               input logic signed [kpu_pkg::DATA_W-1:0] alpha,
                               input logic signed [kpu_pkg::DATA_W-1:0] beta);
    drain_results();
    write_reg(kpu_pkg::CFG_TRANS_A, ($urandom() & 32'hffff_fffe) | 32'(ta));
    write_reg(kpu_pkg::CFG_TRANS_B, ($urandom() & 32'hffff_fffe) | 32'(tb));
    write_reg(kpu_pkg::CFG_ROWS_A, ($urandom() & 32'hffff_ffe0) | 32'(ra));
    write_reg(kpu_pkg::CFG_COLS_A, ($urandom() & 32'hffff_ffe0) | 32'(ca));
    write_reg(kpu_pkg::CFG_ROWS_B, ($urandom() & 32'hffff_ffe0) | 32'(rb));
    write_reg(kpu_pkg::CFG_COLS_B, ($urandom() & 32'hffff_ffe0) | 32'(cb));
    write_reg(kpu_pkg::CFG_ALPHA, alpha);
    write_reg(kpu_pkg::CFG_BETA, beta);
    cfg_valid_i <= 1'b0;
  endtask

  // reset configuration: 1x1 operands, unit alpha, old element ignored
  task automatic test_reset_defaults();
    send_item(kpu_pkg::REQ_LOAD_A, 4'd0, 4'd0, ONE_Q);
    send_item(kpu_pkg::REQ_LOAD_B, 4'd0, 4'd0, 32'sh0002_0000);
    send_update(MAX_Q);
    send_item(REQ_NONE, 4'd15, 4'd15, MIN_Q);
    send_update(32'sh1234_5678);
  endtask

  // rounding on exact halves, saturation, zero beta
  task automatic test_arith_extremes();
    apply_setting(1'b0, 1'b0, 5'd1, 5'd1, 5'd1, 5'd1, ONE_Q, ONE_Q);
    send_item(kpu_pkg::REQ_LOAD_A, 4'd0, 4'd0, 32'sd1);
    send_item(kpu_pkg::REQ_LOAD_B, 4'd0, 4'd0, 32'sh0000_8000);
    send_update('0);
    send_item(kpu_pkg::REQ_LOAD_A, 4'd0, 4'd0, -32'sd1);
    send_update('0);
    send_update(-32'sd1);

    apply_setting(1'b0, 1'b0, 5'd1, 5'd1, 5'd1, 5'd1, MAX_Q, MIN_Q);
    send_item(kpu_pkg::REQ_LOAD_A, 4'd0, 4'd0, MAX_Q);
    send_item(kpu_pkg::REQ_LOAD_B, 4'd0, 4'd0, MIN_Q);
    send_update(MIN_Q);
    send_item(kpu_pkg::REQ_LOAD_B, 4'd0, 4'd0, MAX_Q);
    send_update(MAX_Q);

    apply_setting(1'b0, 1'b0, 5'd1, 5'd1, 5'd1, 5'd1, MIN_Q, '0);
    send_item(kpu_pkg::REQ_LOAD_A, 4'd0, 4'd0, MIN_Q);
    send_item(kpu_pkg::REQ_LOAD_B, 4'd0, 4'd0, MIN_Q);
    send_update(MAX_Q);
    send_item(kpu_pkg::REQ_LOAD_A, 4'd15, 4'd15, MAX_Q);
    send_item(kpu_pkg::REQ_LOAD_B, 4'd15, 4'd15, MIN_Q);
    send_item(REQ_NONE, 4'd0, 4'd0, '0);
    send_update(MIN_Q);
  endtask

  // zero dimension reads as one, oversize reads as the store size
  task automatic test_dim_clamp();
    int n;
    apply_setting(1'b0, 1'b1, 5'd1, 5'd31, 5'd0, 5'd1, ONE_Q, 32'sh0000_8000);
    for (n = 0; n < 34; n++) begin
      send_update(rand_q());
      maybe_idle();
    end
  endtask

  // shrink dimensions part way through a pass so counters sit past the end
  task automatic test_midpass_resize();
    int n;
    apply_setting(1'b0, 1'b1, 5'd2, 5'd2, 5'd16, 5'd2, ONE_Q, 32'sh0000_8000);
    for (n = 0; n < 11; n++) send_update(rand_q());
    apply_setting(1'b1, 1'b0, 5'd2, 5'd1, 5'd3, 5'd2, rand_gain(), rand_gain());
    for (n = 0; n < 30; n++) begin
      send_update(rand_q());
      maybe_idle();
    end
  endtask

  // phases of mixed loads, updates and ignored requests with random idling
  task automatic test_random_phases();
    int                        p;
    int                        n;
    int                        sel;
    logic [kpu_pkg::DIM_W-1:0] ra;
    logic [kpu_pkg::DIM_W-1:0] ca;
    logic [kpu_pkg::DIM_W-1:0] rb;
    logic [kpu_pkg::DIM_W-1:0] cb;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: apply_setting(1'b1, 1'b1, 5'd16, 5'd16, 5'd16, 5'd16, rand_gain(), rand_gain());
        1: apply_setting(1'b0, 1'b0, 5'd1, 5'd1, 5'd1, 5'd1, rand_gain(), rand_gain());
        4: apply_setting(1'b1, 1'b0, 5'd16, 5'd1, 5'd1, 5'd16, rand_gain(), rand_gain());
        default: begin
          ra = pick_dim();
          ca = pick_dim();
          rb = pick_dim();
          cb = pick_dim();
          apply_setting(1'($urandom()), 1'($urandom()), ra, ca, rb, cb, rand_gain(),
                        rand_gain());
        end
      endcase
      for (n = 0; n < 170; n++) begin
        if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        if (p == 2 && n == 85) drain_results();
        sel = $urandom_range(0, 99);
        if (sel < 68) send_update(rand_q());
        else if (sel < 83) send_load(kpu_pkg::REQ_LOAD_A);
        else if (sel < 97) send_load(kpu_pkg::REQ_LOAD_B);
        else send_item(REQ_NONE, kpu_pkg::POS_W'($urandom()), kpu_pkg::POS_W'($urandom()),
                       rand_q());
        maybe_idle();
      end
    end
  endtask

  // back-to-back transactions with no idling at all
  task automatic test_streaming();
    int n;
    int sel;
    apply_setting(1'b1, 1'b1, 5'd3, 5'd2, 5'd2, 5'd4, rand_gain(), rand_gain());
    idle_on = 1'b0;
    for (n = 0; n < 220; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 85) send_update(rand_q());
      else if (sel < 92) send_load(kpu_pkg::REQ_LOAD_A);
      else if (sel < 99) send_load(kpu_pkg::REQ_LOAD_B);
      else send_item(REQ_NONE, kpu_pkg::POS_W'($urandom()), kpu_pkg::POS_W'($urandom()),
                     rand_q());
    end
  endtask

  // test sequence
  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_type_i   = '0;
    elem_row_i   = '0;
    elem_col_i   = '0;
    elem_value_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_arith_extremes();
    test_dim_clamp();
    test_midpass_resize();
    test_random_phases();
    test_streaming();
    drain_results();

    if (err_count == 0) begin
      $display("** kronecker_product_update_core: PASSED **");
    end else begin
      $display("** kronecker_product_update_core: FAILED **");
    end
    $finish;
  end

endmodule
